@@ hdl/tlptm_pkg.sv @@
// Shared types and constants for the two-level page table manager.
package tlptm_pkg;

  localparam int DIR_BITS  = 10;
  localparam int SLOT_BITS = 10;
  localparam int OFS_BITS  = 12;
  localparam int FRAME_BITS = 20;
  localparam int LEAF_BITS = 23;

  localparam logic [1:0] KIND_MAP       = 2'd0;
  localparam logic [1:0] KIND_UNMAP     = 2'd1;
  localparam logic [1:0] KIND_TRANSLATE = 2'd2;

  typedef struct packed {
    logic [1:0]            kind;
    logic [DIR_BITS-1:0]   dslot;
    logic [SLOT_BITS-1:0]  lslot;
    logic [OFS_BITS-1:0]   offset;
    logic [FRAME_BITS-1:0] frame;
    logic                  writable;
    logic                  user_access;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

endpackage

@@ hdl/two_level_page_table_manager.sv @@
// Top level of the two-level page table manager.
// After reset the block clears all 1024 page directory entries, with full
// held high. In the back end each transaction does one directory read; a
// mapped-slot translate adds a leaf read after it, and a map that allocates
// a new page table first clears all 1024 entries of that table through the
// leaf memory write port. A two-entry front queue keeps accepting while a
// result waits; a refused map returns status 1.
module two_level_page_table_manager #(
  parameter int TABLE_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [31:0] virt_addr,
  input  logic [31:0] map_phys,
  input  logic        writable,
  input  logic        user_access,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] phys_out,
  output logic        present,
  output logic        leaf_writable,
  output logic        leaf_user,
  output logic        status
);

  tlptm_pkg::queue_head_t head;
  logic                   pop_item;
  logic                   hold;

  tlptm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .hold        (hold),
    .kind        (kind),
    .virt_addr   (virt_addr),
    .map_phys    (map_phys),
    .writable    (writable),
    .user_access (user_access),
    .head        (head),
    .pop_item    (pop_item)
  );

  tlptm_back #(.TABLE_COUNT(TABLE_COUNT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop_item      (pop_item),
    .hold          (hold),
    .empty         (empty),
    .pop           (pop),
    .phys_out      (phys_out),
    .present       (present),
    .leaf_writable (leaf_writable),
    .leaf_user     (leaf_user),
    .status        (status)
  );

endmodule

@@ hdl/tlptm_front.sv @@
// Front end: splits incoming transactions into fields and queues them.
module tlptm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  logic                  hold,
  input  logic [1:0]            kind,
  input  logic [31:0]           virt_addr,
  input  logic [31:0]           map_phys,
  input  logic                  writable,
  input  logic                  user_access,
  output tlptm_pkg::queue_head_t head,
  input  logic                  pop_item
);

  tlptm_pkg::item_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;
  tlptm_pkg::item_t in_item;

  assign full    = (count == 2'd2) || hold;
  assign do_push = push && !full;
  assign do_pop  = pop_item && (count != 2'd0);

  always_comb begin
    in_item.kind        = kind;
    in_item.dslot       = virt_addr[31:22];
    in_item.lslot       = virt_addr[21:12];
    in_item.offset      = virt_addr[11:0];
    in_item.frame       = map_phys[31:12];
    in_item.writable    = writable;
    in_item.user_access = user_access;
  end

  assign head.valid = (count != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

@@ hdl/tlptm_back.sv @@
// Back end: directory and leaf memories, table allocation and result register.
module tlptm_back #(
  parameter int TABLE_COUNT = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tlptm_pkg::queue_head_t head,
  output logic                   pop_item,
  output logic                   hold,
  output logic                   empty,
  input  logic                   pop,
  output logic [31:0]            phys_out,
  output logic                   present,
  output logic                   leaf_writable,
  output logic                   leaf_user,
  output logic                   status
);

  localparam int TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
  localparam int NW = $clog2(TABLE_COUNT + 1);
  localparam int AW = TW + tlptm_pkg::SLOT_BITS;
  localparam int LEAF_DEPTH = TABLE_COUNT * (1 << tlptm_pkg::SLOT_BITS);
  localparam int DIR_DEPTH = 1 << tlptm_pkg::DIR_BITS;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIR   = 3'd2;
  localparam logic [2:0] S_CLR   = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_LEAF  = 3'd5;

  logic [2:0]               state;
  logic [2:0]               state_next;
  logic [tlptm_pkg::SLOT_BITS-1:0] cnt;
  logic [NW-1:0]            next_free;
  tlptm_pkg::item_t         cur;

  logic [TW:0]              dir_mem [DIR_DEPTH];
  logic [TW:0]              dir_rd;
  logic                     dir_we;
  logic [tlptm_pkg::DIR_BITS-1:0] dir_wa;
  logic [TW:0]              dir_wd;

  logic [tlptm_pkg::LEAF_BITS-1:0] leaf_mem [LEAF_DEPTH];
  logic [tlptm_pkg::LEAF_BITS-1:0] leaf_rd;
  logic                     leaf_we;
  logic [AW-1:0]            leaf_wa;
  logic [tlptm_pkg::LEAF_BITS-1:0] leaf_wd;
  logic                     leaf_re;
  logic [tlptm_pkg::LEAF_BITS-1:0] leaf_new;
  logic [TW-1:0]            alloc_tn;

  logic                     res_we;
  logic [31:0]              res_phys;
  logic                     res_present;
  logic                     res_wr;
  logic                     res_us;
  logic                     res_status;
  logic                     out_valid;

  assign hold     = (state == S_INIT);
  assign empty    = !out_valid;
  assign pop_item = (state == S_IDLE) && head.valid && !out_valid;
  assign alloc_tn = TW'(next_free);
  assign leaf_new = {cur.frame, cur.user_access, cur.writable, 1'b1};

  always_comb begin
    state_next  = state;
    dir_we      = 1'b0;
    dir_wa      = cur.dslot;
    dir_wd      = {1'b1, alloc_tn};
    leaf_we     = 1'b0;
    leaf_wa     = {dir_rd[TW-1:0], cur.lslot};
    leaf_wd     = '0;
    leaf_re     = 1'b0;
    res_we      = 1'b0;
    res_phys    = '0;
    res_present = 1'b0;
    res_wr      = 1'b0;
    res_us      = 1'b0;
    res_status  = 1'b0;
    unique case (state)
      S_INIT: begin
        dir_we = 1'b1;
        dir_wa = cnt;
        dir_wd = '0;
        if (&cnt) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (pop_item) state_next = S_DIR;
      end
      S_DIR: begin
        state_next = S_IDLE;
        res_we     = 1'b1;
        priority if (cur.kind == tlptm_pkg::KIND_MAP) begin
          if (dir_rd[TW]) begin
            leaf_we = 1'b1;
            leaf_wd = leaf_new;
          end else if (next_free == NW'(TABLE_COUNT)) begin
            res_status = 1'b1;
          end else begin
            res_we     = 1'b0;
            state_next = S_CLR;
          end
        end else if (cur.kind == tlptm_pkg::KIND_UNMAP) begin
          leaf_we = dir_rd[TW];
        end else if (cur.kind == tlptm_pkg::KIND_TRANSLATE) begin
          if (dir_rd[TW]) begin
            leaf_re    = 1'b1;
            res_we     = 1'b0;
            state_next = S_LEAF;
          end
        end else begin
          res_we = 1'b1;
        end
      end
      S_CLR: begin
        leaf_we = 1'b1;
        leaf_wa = {alloc_tn, cnt};
        if (&cnt) state_next = S_ALLOC;
      end
      S_ALLOC: begin
        dir_we     = 1'b1;
        leaf_we    = 1'b1;
        leaf_wa    = {alloc_tn, cur.lslot};
        leaf_wd    = leaf_new;
        res_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_LEAF: begin
        res_we      = 1'b1;
        res_present = leaf_rd[0];
        res_wr      = leaf_rd[0] & leaf_rd[1];
        res_us      = leaf_rd[0] & leaf_rd[2];
        res_phys    = leaf_rd[0] ? {leaf_rd[22:3], cur.offset} : 32'd0;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[dir_wa] <= dir_wd;
    if (pop_item) dir_rd <= dir_mem[head.item.dslot];
  end

  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_wa] <= leaf_wd;
    if (leaf_re) leaf_rd <= leaf_mem[{dir_rd[TW-1:0], cur.lslot}];
  end

  always_ff @(posedge clk) begin
    if (pop_item) cur <= head.item;
    if (res_we) begin
      phys_out      <= res_phys;
      present       <= res_present;
      leaf_writable <= res_wr;
      leaf_user     <= res_us;
      status        <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      next_free <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT || state == S_CLR) cnt <= cnt + 1'b1;
      if (state == S_ALLOC) next_free <= next_free + 1'b1;
      if (res_we) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/tlptm_checker.sv @@
// Port-level checks for the page table manager, bound to the top level.
module tlptm_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [31:0] phys_out,
  input logic        present,
  input logic        leaf_writable,
  input logic        leaf_user,
  input logic        status
);

  a_init_full: assert property (@(posedge clk) rst |=> full)
    else $error("full low right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(phys_out) && $stable(status)))
    else $error("waiting result changed");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !present) |-> (phys_out == 32'd0 && !leaf_writable && !leaf_user))
    else $error("absent result not zero");

  a_refused: assert property (@(posedge clk) disable iff (rst)
    (!empty && status) |-> !present)
    else $error("refused map reports present");

endmodule

bind two_level_page_table_manager tlptm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .full          (full),
  .empty         (empty),
  .pop           (pop),
  .phys_out      (phys_out),
  .present       (present),
  .leaf_writable (leaf_writable),
  .leaf_user     (leaf_user),
  .status        (status)
);
